// File: design/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
// Used by sfr_cfg, sfr_core, sfr_burst and stream_find_replace.
`default_nettype none

package sfr_pkg;

  // Width of a burst word count (bursts hold at most eight words)
  localparam int CNT_W = 4;
  // Width of the reported match total
  localparam int MATCH_W = 16;
  // Width of the register data bus
  localparam int CFG_DW = 64;
  // Width of the register byte address
  localparam int CFG_AW = 5;

  // Register indexes, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } reg_index_t;

  // Register contents plus the pulse that drops pending window bytes
  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic [63:0] replacement_bytes;
    logic [3:0]  replacement_length;
    logic        fill_clear;
  } cfg_t;

  // Control of one result burst handed from the core to the output buffer
  typedef struct packed {
    logic               load;
    logic [CNT_W-1:0]   count;
    logic               byte_valid;
    logic               text_end;
    logic [MATCH_W-1:0] match_total;
  } batch_t;

endpackage

`default_nettype wire

// File: design/sfr_cfg.sv
// APB register file of the find-and-replace block: pattern, replacement, lengths.
// Depends on sfr_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module sfr_cfg import sfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;
  logic        wr;
  reg_index_t  idx;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[4:3]);
  assign wr     = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (wr) begin
      case (idx)
        REG_PATTERN_BYTES:      pattern_bytes      <= pwdata;
        REG_PATTERN_LENGTH:     pattern_length     <= pwdata[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= pwdata;
        REG_REPLACEMENT_LENGTH: replacement_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_PATTERN_BYTES:      prdata = pattern_bytes;
      REG_PATTERN_LENGTH:     prdata = {60'd0, pattern_length};
      REG_REPLACEMENT_BYTES:  prdata = replacement_bytes;
      REG_REPLACEMENT_LENGTH: prdata = {60'd0, replacement_length};
      default:                prdata = '0;
    endcase
  end

  // Bundle for the core; a pattern length write drops pending bytes
  always_comb begin
    cfg.pattern_bytes      = pattern_bytes;
    cfg.pattern_length     = pattern_length;
    cfg.replacement_bytes  = replacement_bytes;
    cfg.replacement_length = replacement_length;
    cfg.fill_clear         = wr && (idx == REG_PATTERN_LENGTH);
  end

endmodule

`default_nettype wire

// File: design/sfr_core.sv
// Match core: pending window, match compare, match counter and burst build.
// Depends on sfr_pkg for cfg_t and batch_t.
`default_nettype none

module sfr_core import sfr_pkg::*; #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8,
  parameter int COUNT_BITS      = 16,
  parameter int BATCH           = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             end_of_text,
  input  wire cfg_t             cfg,
  output batch_t                batch,
  output logic [BATCH*8-1:0]    batch_bytes
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int REPL_W = $clog2(MAX_REPLACEMENT + 1);

  logic [7:0]            window [MAX_PATTERN];
  logic [7:0]            window_next [MAX_PATTERN];
  logic [7:0]            w [MAX_PATTERN];
  logic [7:0]            wb [BATCH];
  logic [7:0]            rb [BATCH];
  logic [7:0]            ob [BATCH];
  logic [FILL_W-1:0]     fill, fill_next, f, plen;
  logic [REPL_W-1:0]     rlen;
  logic [COUNT_BITS-1:0] match_counter, match_counter_next, counter_inc, counter_after;
  logic [31:0]           counter_wide;
  logic [MATCH_W-1:0]    shown;
  logic [CNT_W-1:0]      cnt;
  logic                  full, hit, take_hit;

  // Clamp lengths, place the new byte, compare against the pattern
  always_comb begin
    plen = (cfg.pattern_length > 4'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN)
                                                  : FILL_W'(cfg.pattern_length);
    rlen = (cfg.replacement_length > 4'(MAX_REPLACEMENT)) ? REPL_W'(MAX_REPLACEMENT)
                                                          : REPL_W'(cfg.replacement_length);
    f    = (fill >= plen) ? '0 : fill;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w[i] = (FILL_W'(i) == f) ? data_byte : window[i];
    end
    full = (plen != '0) && ((f + 1'b1) == plen);
    hit  = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((FILL_W'(i) < plen) && (w[i] != cfg.pattern_bytes[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
    take_hit = full && hit;
  end

  // Build burst: pass-through, replacement, flushed window, or oldest byte
  always_comb begin
    for (int i = 0; i < BATCH; i++) begin
      wb[i] = '0;
      rb[i] = '0;
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      wb[i] = w[i];
    end
    for (int i = 0; i < MAX_REPLACEMENT; i++) begin
      rb[i] = cfg.replacement_bytes[8*i +: 8];
    end
    ob = wb;
    cnt = '0;
    if (plen == '0) begin
      ob[0] = data_byte;
      cnt   = CNT_W'(1);
    end else if (take_hit) begin
      ob  = rb;
      cnt = CNT_W'(rlen);
    end else if (end_of_text) begin
      cnt = CNT_W'(f) + 1'b1;
    end else if (full) begin
      cnt = CNT_W'(1);
    end
    for (int i = 0; i < BATCH; i++) begin
      batch_bytes[8*i +: 8] = ob[i];
    end
  end

  // Advance window and counter
  always_comb begin
    counter_inc = (match_counter == '1) ? match_counter : match_counter + 1'b1;
    window_next = window;
    fill_next   = fill;
    counter_after = match_counter;
    if (plen != '0) begin
      if (take_hit) begin
        fill_next     = '0;
        counter_after = counter_inc;
      end else if (full) begin
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          window_next[i] = w[i + 1];
        end
        window_next[MAX_PATTERN - 1] = w[MAX_PATTERN - 1];
        fill_next = plen - 1'b1;
      end else begin
        window_next = w;
        fill_next   = f + 1'b1;
      end
    end
    match_counter_next = counter_after;
    if (end_of_text) begin
      fill_next          = '0;
      match_counter_next = '0;
    end
    counter_wide = 32'(counter_after);
    shown = (counter_wide > 32'h0000_FFFF) ? '1 : counter_wide[MATCH_W-1:0];
  end

  // Burst control for the output buffer
  always_comb begin
    batch.load        = accept && ((cnt != '0) || end_of_text);
    batch.count       = (cnt == '0) ? CNT_W'(1) : cnt;
    batch.byte_valid  = (cnt != '0);
    batch.text_end    = end_of_text;
    batch.match_total = shown;
  end

  // Hold fill and match count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      match_counter <= '0;
    end else begin
      if (cfg.fill_clear) begin
        fill <= '0;
      end else if (accept) begin
        fill <= fill_next;
      end
      if (accept) begin
        match_counter <= match_counter_next;
      end
    end
  end

  // Window bytes beyond the fill are never read
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

`default_nettype wire

// File: design/sfr_burst.sv
// Output buffer holds one burst, sends one word per cycle on m_tready.
// Depends on sfr_pkg for batch_t and field widths.
`default_nettype none

module sfr_burst import sfr_pkg::*; #(
  parameter int BATCH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire batch_t             batch,
  input  wire logic [BATCH*8-1:0] batch_bytes,
  output logic                    s_ready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [23:0]             m_tdata,
  output logic [1:0]              m_tuser,
  output logic                    m_tlast
);

  logic [7:0]         bytes [BATCH];
  logic [CNT_W-1:0]   rem;
  logic               busy, byte_valid_q, text_end_q, last, take;
  logic [MATCH_W-1:0] total_q;

  assign last    = (rem == CNT_W'(1));
  assign take    = busy && m_tready;
  assign s_ready = !busy || (m_tready && last);

  // Track burst occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem  <= '0;
    end else if (batch.load) begin
      busy <= 1'b1;
      rem  <= batch.count;
    end else if (take) begin
      rem <= rem - 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // Load the burst, shift one word out per take
  always_ff @(posedge clk) begin
    if (batch.load) begin
      for (int i = 0; i < BATCH; i++) begin
        bytes[i] <= batch_bytes[8*i +: 8];
      end
      byte_valid_q <= batch.byte_valid;
      text_end_q   <= batch.text_end;
      total_q      <= batch.match_total;
    end else if (take) begin
      for (int i = 0; i < BATCH - 1; i++) begin
        bytes[i] <= bytes[i + 1];
      end
      bytes[BATCH - 1] <= '0;
    end
  end

  assign m_tvalid = busy;
  assign m_tdata  = {total_q, (byte_valid_q ? bytes[0] : 8'h00)};
  assign m_tuser  = {last, byte_valid_q};
  assign m_tlast  = last && text_end_q;

endmodule

`default_nettype wire

// File: design/stream_find_replace.sv
// Stream find-and-replace with registered output words. An item yields 0 to 8 words;
// input is taken every cycle while items yield at most one word and m_tready is high;
// a longer burst holds input until its last word is taken (one output buffer).
// Synchronous reset clears registers, window fill, match count and the output buffer.
// Built from sfr_cfg (APB registers), sfr_core (window, compare) and sfr_burst (output).
`default_nettype none

module stream_find_replace import sfr_pkg::*; #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8,
  parameter int COUNT_BITS      = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Input words
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // data_byte[7:0]
  input  wire logic              s_tlast,   // end_of_text
  // Output words
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [23:0]            m_tdata,   // out_byte[7:0], match_total[23:8]
  output logic [1:0]             m_tuser,   // byte_valid[0], run_last[1]
  output logic                   m_tlast,   // text_done
  // Register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int BATCH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;

  cfg_t               cfg;
  batch_t             batch;
  logic [BATCH*8-1:0] batch_bytes;
  logic               accept;

  assign accept = s_tvalid && s_tready;

  sfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfr_core #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .COUNT_BITS      (COUNT_BITS),
    .BATCH           (BATCH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata),
    .end_of_text (s_tlast),
    .cfg         (cfg),
    .batch       (batch),
    .batch_bytes (batch_bytes)
  );

  sfr_burst #(
    .BATCH (BATCH)
  ) u_burst (
    .clk         (clk),
    .rst         (rst),
    .batch       (batch),
    .batch_bytes (batch_bytes),
    .s_ready     (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  // An empty output buffer always takes input
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output buffer");

  // End of text always closes the run of its item
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tlast) |-> m_tuser[1])
    else $error("text end without run end");

  // An empty marker word is the final word of a text and carries a zero byte
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata[7:0] == 8'h00)))
    else $error("empty marker word not at end of text");

  // An accepted end-of-text word always yields an output word on the next cycle
  assert property (@(posedge clk) disable iff (rst) (accept && s_tlast) |=> m_tvalid)
    else $error("end of text produced no output word");

endmodule

`default_nettype wire

// File: bench/stream_find_replace_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for stream_find_replace: a directed table, then random text rich in
// pattern copies, checked word by word against a behavioral find-and-replace predictor.
// Depends on sfr_pkg and the stream_find_replace design files.

module stream_find_replace_tb;
  import sfr_pkg::*;

  localparam int WIN_MAX       = 8;
  localparam int REP_MAX       = 8;
  localparam int COUNT_MAX     = 65535;
  localparam int SETTLE_CYCLES = 6;
  localparam int SEG_WORDS     = 50;

  // One output word, split into its fields
  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               run_last;
    logic               text_done;
    logic [MATCH_W-1:0] match_total;
  } out_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    reg_index_t idx;
    logic [63:0] value;
    logic [7:0] data;
    logic       last;
    logic       typed;
    out_word_t  want;
  } plan_row_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  wire               s_tready;
  logic [7:0]        s_tdata  = '0;   // data_byte[7:0]
  logic              s_tlast  = 1'b0; // end_of_text
  wire               m_tvalid;
  logic              m_tready = 1'b0;
  wire [23:0]        m_tdata;         // out_byte[7:0], match_total[23:8]
  wire [1:0]         m_tuser;         // byte_valid[0], run_last[1]
  wire               m_tlast;         // text_done
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [CFG_AW-1:0] paddr    = '0;
  logic [CFG_DW-1:0] pwdata   = '0;
  wire  [CFG_DW-1:0] prdata;
  wire               pready;

  // Predictor copy of registers and window state
  logic [63:0] pat_bytes = '0;
  logic [63:0] rep_bytes = '0;
  logic [3:0]  pat_len   = '0;
  logic [3:0]  rep_len   = '0;
  logic [7:0]  window [WIN_MAX];
  int          fill        = 0;
  int          match_count = 0;

  out_word_t   due_words[$];
  out_word_t   step_words[$];
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  int seg_pat_len [9] = '{1, 3, 8, 0, 2, 15, 5, 8, 4};
  int seg_rep_len [9] = '{2, 0, 8, 1, 15, 3, 0, 8, 5};

  stream_find_replace uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset, then release it on a falling edge
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic out_word_t make_word(input logic [7:0] b, input logic v);
    out_word_t w;
    w = '0;
    w.out_byte = b;
    w.byte_valid = v;
    return w;
  endfunction

  // Compute the words one input byte produces and advance the window
  function automatic void find_replace_step(input logic [7:0] d, input logic e);
    int   plen;
    int   rlen;
    int   i;
    int   n;
    logic hit;
    step_words.delete();
    plen = (pat_len > WIN_MAX) ? WIN_MAX : int'(pat_len);
    rlen = (rep_len > REP_MAX) ? REP_MAX : int'(rep_len);
    if (plen == 0) begin
      step_words.push_back(make_word(d, 1'b1));
    end else begin
      if (fill >= plen) fill = 0;
      window[fill] = d;
      fill++;
      if (fill == plen) begin
        hit = 1'b1;
        for (i = 0; i < plen; i++) begin
          if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (i = 0; i < rlen; i++) step_words.push_back(make_word(rep_bytes[8*i +: 8], 1'b1));
          if (match_count < COUNT_MAX) match_count++;
          fill = 0;
        end else begin
          // emit the oldest byte and shift the rest down
          step_words.push_back(make_word(window[0], 1'b1));
          for (i = 1; i < plen; i++) window[i-1] = window[i];
          fill--;
        end
      end
    end
    // flush on end of text, empty marker if nothing came out
    if (e) begin
      for (i = 0; i < fill; i++) step_words.push_back(make_word(window[i], 1'b1));
      fill = 0;
      if (step_words.size() == 0) step_words.push_back(make_word(8'h00, 1'b0));
    end
    foreach (step_words[k]) step_words[k].match_total = MATCH_W'(match_count);
    n = step_words.size();
    if (n > 0) begin
      step_words[n-1].run_last = 1'b1;
      if (e) step_words[n-1].text_done = 1'b1;
    end
    if (e) begin
      foreach (window[j]) window[j] = '0;
      match_count = 0;
    end
  endfunction

  function automatic plan_row_t reg_row(input reg_index_t idx, input logic [63:0] value);
    plan_row_t r;
    r = '{ROW_REG, idx, value, 8'h00, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t word_row(input logic [7:0] d, input logic l);
    plan_row_t r;
    r = '{ROW_WORD, REG_PATTERN_BYTES, 64'd0, d, l, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [7:0] d, input logic l,
                                          input out_word_t want);
    plan_row_t r;
    r = '{ROW_WORD, REG_PATTERN_BYTES, 64'd0, d, l, 1'b1, want};
    return r;
  endfunction

  function automatic logic text_end();
    return $urandom_range(19) == 0;
  endfunction

  // Byte close to the pattern alphabet, or fully random when wild
  function automatic logic [7:0] noise_byte(input logic wild);
    int idx;
    idx = $urandom_range(7);
    if (wild) return 8'($urandom_range(255));
    if ($urandom_range(1) == 1) return pat_bytes[8*idx +: 8];
    return 8'h41 + 8'($urandom_range(1));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Present one word, wait for acceptance, queue its expected output
  task automatic send_word(input logic [7:0] d, input logic l,
                           input logic typed = 1'b0, input out_word_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    find_replace_step(d, l);
    if (typed) due_words.push_back(want);
    else foreach (step_words[k]) due_words.push_back(step_words[k]);
    @(negedge clk);
  endtask

  // Two-phase register write; predictor copy updates at the access edge
  task automatic apb_write(input reg_index_t idx, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_PATTERN_BYTES: pat_bytes = v;
      REG_PATTERN_LENGTH: begin
        pat_len = v[3:0];
        fill = 0;
      end
      REG_REPLACEMENT_BYTES: rep_bytes = v;
      REG_REPLACEMENT_LENGTH: rep_len = v[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending, wait for every expected word, then let the pipeline settle
  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random text: mostly whole pattern copies and broken prefixes, some noise
  task automatic send_random_text(input int n);
    int sent;
    int plen;
    int cut;
    int k;
    int i;
    sent = 0;
    plen = (pat_len > WIN_MAX) ? WIN_MAX : int'(pat_len);
    while (sent < n) begin
      k = $urandom_range(9);
      cut = 0;
      if (k < 4) cut = plen;
      else if (k < 6 && plen > 1) cut = $urandom_range(plen - 1);
      for (i = 0; i < cut; i++) begin
        send_word(pat_bytes[8*i +: 8], text_end());
        sent++;
      end
      if (k >= 4 || plen == 0) begin
        send_word(noise_byte(k == 9), text_end());
        sent++;
      end
    end
  endtask

  // Randomize the receiver stall every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word tdata %h tuser %b", m_tdata, m_tuser));
      end else begin
        want = due_words.pop_front();
        check_field("out_byte", m_tdata[7:0], want.out_byte);
        check_field("match_total", m_tdata[23:8], want.match_total);
        check_field("byte_valid", m_tuser[0], want.byte_valid);
        check_field("run_last", m_tuser[1], want.run_last);
        check_field("text_done", m_tlast, want.text_done);
      end
    end
  end

  initial begin
    plan_row_t   plan[$];
    int          stage;
    int          seg;
    int          i;
    logic [63:0] pb;
    foreach (window[j]) window[j] = '0;

    // pass-through after reset, then a two-byte pattern with a three-byte replacement
    plan.push_back(typed_row(8'h00, 1'b0, out_word_t'{8'h00, 1'b1, 1'b1, 1'b0, 16'd0}));
    plan.push_back(typed_row(8'hFF, 1'b1, out_word_t'{8'hFF, 1'b1, 1'b1, 1'b1, 16'd0}));
    plan.push_back(reg_row(REG_PATTERN_BYTES, 64'h6261));
    plan.push_back(reg_row(REG_PATTERN_LENGTH, 64'd2));
    plan.push_back(reg_row(REG_REPLACEMENT_BYTES, 64'h7A7978));
    plan.push_back(reg_row(REG_REPLACEMENT_LENGTH, 64'd3));
    plan.push_back(word_row(8'h61, 1'b0));
    plan.push_back(word_row(8'h62, 1'b0));
    plan.push_back(word_row(8'h61, 1'b0));
    plan.push_back(word_row(8'h61, 1'b0));
    plan.push_back(word_row(8'h62, 1'b0));
    plan.push_back(word_row(8'h71, 1'b1));
    plan.push_back(word_row(8'h61, 1'b1));
    // deleting replacement: a match at end of text leaves only the empty marker
    plan.push_back(reg_row(REG_REPLACEMENT_LENGTH, 64'd0));
    plan.push_back(word_row(8'h61, 1'b0));
    plan.push_back(typed_row(8'h62, 1'b1, out_word_t'{8'h00, 1'b0, 1'b1, 1'b1, 16'd1}));
    // rewriting the pattern length drops the pending byte
    plan.push_back(word_row(8'h61, 1'b0));
    plan.push_back(reg_row(REG_PATTERN_LENGTH, 64'd2));
    plan.push_back(word_row(8'h62, 1'b1));
    // lengths above the maximum act as eight
    plan.push_back(reg_row(REG_PATTERN_BYTES, 64'hFF80_7F01_FE00_55AA));
    plan.push_back(reg_row(REG_PATTERN_LENGTH, 64'hF));
    plan.push_back(reg_row(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF));
    plan.push_back(reg_row(REG_REPLACEMENT_LENGTH, 64'hF));
    plan.push_back(word_row(8'hAA, 1'b0));
    plan.push_back(word_row(8'h55, 1'b0));
    plan.push_back(word_row(8'h00, 1'b0));
    plan.push_back(word_row(8'hFE, 1'b0));
    plan.push_back(word_row(8'h01, 1'b0));
    plan.push_back(word_row(8'h7F, 1'b0));
    plan.push_back(word_row(8'h80, 1'b0));
    plan.push_back(word_row(8'hFF, 1'b1));

    while (rst) @(negedge clk);
    @(negedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 76;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        drain_and_settle();
        apb_write(plan[r].idx, plan[r].value);
      end else begin
        send_word(plan[r].data, plan[r].last, plan[r].typed, plan[r].want);
      end
    end

    // Random phases: three settings per idling profile
    for (stage = 0; stage < 3; stage++) begin
      drain_and_settle();
      case (stage)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (i = 0; i < 3; i++) begin
        seg = stage * 3 + i;
        for (int b = 0; b < 8; b++) begin
          if ($urandom_range(1) == 1) pb[8*b +: 8] = 8'h41 + 8'($urandom_range(1));
          else pb[8*b +: 8] = 8'($urandom_range(255));
        end
        drain_and_settle();
        apb_write(REG_PATTERN_BYTES, pb);
        apb_write(REG_PATTERN_LENGTH, 64'(seg_pat_len[seg]));
        apb_write(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
        apb_write(REG_REPLACEMENT_LENGTH, 64'(seg_rep_len[seg]));
        send_random_text(SEG_WORDS);
      end
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/sfr_pkg.sv
design/sfr_cfg.sv
design/sfr_core.sv
design/sfr_burst.sv
design/stream_find_replace.sv
bench/stream_find_replace_tb.sv
